// ===== sv/sbq_pkg.sv =====
// Package for the segment basis to quaternion core.
// Holds fixed-point constants and small helpers shared by the core and the normalizer.
// No dependencies.
package sbq_pkg;

   localparam logic [63:0] EPS_SQ_Q64 = 64'd1844674407;
   localparam logic [31:0] HINT_LIMIT = 32'd966367642;
   localparam logic [31:0] UNIT_ONE   = 32'h4000_0000;

   typedef logic [2:0][31:0] axis_type;

   // position of the highest set bit, zero for a zero word
   function automatic logic [5:0] msb_pos(input logic [63:0] v);
      logic [5:0] pos;
      pos = '0;
      for (int i = 0; i < 64; i++) begin
         if (v[i]) pos = 6'(i);
      end
      return pos;
   endfunction

   // right shift by 30, rounding half away from zero
   function automatic logic signed [35:0] rnd30(input logic signed [65:0] v);
      logic [65:0] mag;
      logic [65:0] r;
      mag = v[65] ? 66'(-v) : 66'(v);
      r   = (mag + 66'(1 << 29)) >> 30;
      return v[65] ? -$signed(r[35:0]) : $signed(r[35:0]);
   endfunction

endpackage

// ===== sv/sbq_norm.sv =====
// Pipelined vector normalizer: prescale, sum of squares, threshold, bit-serial
// square root one bit per stage, then restoring division one quotient bit per stage.
// Depends on sbq_pkg.
module sbq_norm #(
   parameter int N       = 3,
   parameter int VW      = 34,
   parameter int FRAC    = 30,
   parameter int USE_EPS = 1,
   parameter int SIDE_W  = 1
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      en,
   input  logic                      in_valid,
   input  logic [N-1:0][VW-1:0]      vec_i,
   input  logic signed [7:0]         uexp_i,
   input  logic [SIDE_W-1:0]         side_i,
   output logic                      out_valid,
   output logic                      out_ok,
   output logic [N-1:0][31:0]        out_comp,
   output logic [SIDE_W-1:0]         side_o
);
   import sbq_pkg::*;

   localparam int SQ_STEPS = 31;
   localparam int DV_STEPS = FRAC + 1;
   localparam int PW       = FRAC + 31;

   typedef struct packed {
      logic                ok;
      logic [N-1:0]        neg;
      logic [N-1:0][29:0]  m;
      logic [61:0]         s;
      logic [30:0]         root;
      logic [33:0]         rem;
      logic [SIDE_W-1:0]   side;
   } sq_type;

   typedef struct packed {
      logic                ok;
      logic [N-1:0]        neg;
      logic [30:0]         len;
      logic [N-1:0][PW-1:0] p;
      logic [N-1:0][FRAC:0] q;
      logic [SIDE_W-1:0]   side;
   } dv_type;

   // stage A: magnitudes and prescale exponent
   logic                 a_valid_ff;
   logic [N-1:0][VW-1:0] a_mag_ff, a_mag_in;
   logic [N-1:0]         a_neg_ff, a_neg_in;
   logic signed [7:0]    a_k_ff, a_k_in, a_uexp_ff;
   logic [SIDE_W-1:0]    a_side_ff;

   always_comb begin
      logic [VW-1:0] mx;
      mx = '0;
      for (int i = 0; i < N; i++) begin
         a_neg_in[i] = vec_i[i][VW-1];
         a_mag_in[i] = vec_i[i][VW-1] ? (~vec_i[i] + 1'b1) : vec_i[i];
         if (a_mag_in[i] > mx) mx = a_mag_in[i];
      end
      a_k_in = 8'sd29 - $signed({2'b00, msb_pos(64'(mx))});
   end

   always_ff @(posedge clock) begin
      if (reset) a_valid_ff <= 1'b0;
      else if (en) a_valid_ff <= in_valid;
      if (en) begin
         a_mag_ff  <= a_mag_in;
         a_neg_ff  <= a_neg_in;
         a_k_ff    <= a_k_in;
         a_uexp_ff <= uexp_i;
         a_side_ff <= side_i;
      end
   end

   // stage B: scaled magnitudes and threshold exponent
   logic                 b_valid_ff;
   logic [N-1:0][29:0]   b_m_ff, b_m_in;
   logic [N-1:0]         b_neg_ff;
   logic signed [9:0]    b_t_ff, b_t_in;
   logic [SIDE_W-1:0]    b_side_ff;

   always_comb begin
      logic [63:0] ext;
      logic [7:0]  nk;
      logic signed [9:0] ksx, usx;
      nk = 8'(-a_k_ff);
      for (int i = 0; i < N; i++) begin
         ext = 64'(a_mag_ff[i]);
         b_m_in[i] = a_k_ff[7] ? 30'(ext >> nk) : 30'(ext << a_k_ff);
      end
      ksx = {{2{a_k_ff[7]}}, a_k_ff};
      usx = {{2{a_uexp_ff[7]}}, a_uexp_ff};
      b_t_in = ksx + ksx - usx - usx - 10'sd64;
   end

   always_ff @(posedge clock) begin
      if (reset) b_valid_ff <= 1'b0;
      else if (en) b_valid_ff <= a_valid_ff;
      if (en) begin
         b_m_ff    <= b_m_in;
         b_neg_ff  <= a_neg_ff;
         b_t_ff    <= b_t_in;
         b_side_ff <= a_side_ff;
      end
   end

   // stage C: squares
   logic                 c_valid_ff;
   logic [N-1:0][59:0]   c_sq_ff;
   logic [N-1:0][29:0]   c_m_ff;
   logic [N-1:0]         c_neg_ff;
   logic signed [9:0]    c_t_ff;
   logic [SIDE_W-1:0]    c_side_ff;

   always_ff @(posedge clock) begin
      if (reset) c_valid_ff <= 1'b0;
      else if (en) c_valid_ff <= b_valid_ff;
      if (en) begin
         for (int i = 0; i < N; i++) c_sq_ff[i] <= b_m_ff[i] * b_m_ff[i];
         c_m_ff    <= b_m_ff;
         c_neg_ff  <= b_neg_ff;
         c_t_ff    <= b_t_ff;
         c_side_ff <= b_side_ff;
      end
   end

   // stage D: sum and degeneracy test, into the root pipeline
   sq_type               sq_ff [SQ_STEPS+1];
   logic [SQ_STEPS:0]    sqv_ff;
   sq_type               sq0_in;

   always_comb begin
      logic [61:0] s;
      logic [63:0] thr;
      logic [9:0]  nt;
      logic        deg;
      s = '0;
      for (int i = 0; i < N; i++) s = s + 62'(c_sq_ff[i]);
      nt  = 10'(-c_t_ff);
      thr = c_t_ff[9] ? (EPS_SQ_Q64 >> nt[4:0]) : (EPS_SQ_Q64 << c_t_ff[4:0]);
      deg = (c_t_ff >= 10'sd32) || ((c_t_ff > -10'sd32) && (64'(s) <= thr));
      sq0_in.ok   = (s != '0) && !((USE_EPS != 0) && deg);
      sq0_in.neg  = c_neg_ff;
      sq0_in.m    = c_m_ff;
      sq0_in.s    = s;
      sq0_in.root = '0;
      sq0_in.rem  = '0;
      sq0_in.side = c_side_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) sqv_ff[0] <= 1'b0;
      else if (en) sqv_ff[0] <= c_valid_ff;
      if (en) sq_ff[0] <= sq0_in;
   end

   for (genvar g = 0; g < SQ_STEPS; g++) begin : g_sq
      localparam int BP = 2 * (SQ_STEPS - 1 - g);
      sq_type sq_in;
      always_comb begin
         logic [35:0] rem_n, trial;
         rem_n = {sq_ff[g].rem, sq_ff[g].s[BP+1:BP]};
         trial = {3'b000, sq_ff[g].root, 2'b01};
         sq_in = sq_ff[g];
         if (rem_n >= trial) begin
            sq_in.rem  = 34'(rem_n - trial);
            sq_in.root = {sq_ff[g].root[29:0], 1'b1};
         end else begin
            sq_in.rem  = 34'(rem_n);
            sq_in.root = {sq_ff[g].root[29:0], 1'b0};
         end
      end
      always_ff @(posedge clock) begin
         if (reset) sqv_ff[g+1] <= 1'b0;
         else if (en) sqv_ff[g+1] <= sqv_ff[g];
         if (en) sq_ff[g+1] <= sq_in;
      end
   end

   // division setup: dividend is m * 2^FRAC + floor(len / 2)
   dv_type               dv_ff [DV_STEPS+1];
   logic [DV_STEPS:0]    dvv_ff;
   dv_type               dv0_in;

   always_comb begin
      dv0_in.ok   = sq_ff[SQ_STEPS].ok;
      dv0_in.neg  = sq_ff[SQ_STEPS].neg;
      dv0_in.len  = sq_ff[SQ_STEPS].root;
      dv0_in.side = sq_ff[SQ_STEPS].side;
      for (int i = 0; i < N; i++) begin
         dv0_in.p[i] = (PW'(sq_ff[SQ_STEPS].m[i]) << FRAC)
                     + PW'(sq_ff[SQ_STEPS].root >> 1);
         dv0_in.q[i] = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) dvv_ff[0] <= 1'b0;
      else if (en) dvv_ff[0] <= sqv_ff[SQ_STEPS];
      if (en) dv_ff[0] <= dv0_in;
   end

   for (genvar g = 0; g < DV_STEPS; g++) begin : g_dv
      localparam int J = FRAC - g;
      dv_type dv_in;
      always_comb begin
         logic [PW-1:0] ls;
         ls = PW'(dv_ff[g].len) << J;
         dv_in = dv_ff[g];
         for (int i = 0; i < N; i++) begin
            if (dv_ff[g].p[i] >= ls) begin
               dv_in.p[i]    = dv_ff[g].p[i] - ls;
               dv_in.q[i][J] = 1'b1;
            end
         end
      end
      always_ff @(posedge clock) begin
         if (reset) dvv_ff[g+1] <= 1'b0;
         else if (en) dvv_ff[g+1] <= dvv_ff[g];
         if (en) dv_ff[g+1] <= dv_in;
      end
   end

   // output: apply signs
   logic                 o_valid_ff;
   logic                 o_ok_ff;
   logic [N-1:0][31:0]   o_comp_ff, o_comp_in;
   logic [SIDE_W-1:0]    o_side_ff;

   always_comb begin
      logic [31:0] qv;
      for (int i = 0; i < N; i++) begin
         qv = 32'(dv_ff[DV_STEPS].q[i]);
         o_comp_in[i] = dv_ff[DV_STEPS].neg[i] ? (~qv + 1'b1) : qv;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) o_valid_ff <= 1'b0;
      else if (en) o_valid_ff <= dvv_ff[DV_STEPS];
      if (en) begin
         o_ok_ff   <= dv_ff[DV_STEPS].ok;
         o_comp_ff <= o_comp_in;
         o_side_ff <= dv_ff[DV_STEPS].side;
      end
   end

   assign out_valid = o_valid_ff;
   assign out_ok    = o_ok_ff;
   assign out_comp  = o_comp_ff;
   assign side_o    = o_side_ff;

endmodule

// ===== sv/segment_basis_to_quaternion_core.sv =====
// Throughput: one transaction per cycle unless stalled; four chained normalizers,
// each with a 31-stage square root and a one-bit-per-stage divider, set the depth.
// A held result stalls the whole pipeline; nothing is lost or repeated.
// Reset (synchronous) clears all valid bits; no clearing pass, no state kept.
module segment_basis_to_quaternion_core #(
   parameter int COORD_WIDTH    = 32,
   parameter int QUAT_FRAC_BITS = 30
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic signed [COORD_WIDTH-1:0] req_parent_x,
   input  logic signed [COORD_WIDTH-1:0] req_parent_y,
   input  logic signed [COORD_WIDTH-1:0] req_parent_z,
   input  logic signed [COORD_WIDTH-1:0] req_child_x,
   input  logic signed [COORD_WIDTH-1:0] req_child_y,
   input  logic signed [COORD_WIDTH-1:0] req_child_z,
   input  logic signed [COORD_WIDTH-1:0] req_palm_x,
   input  logic signed [COORD_WIDTH-1:0] req_palm_y,
   input  logic signed [COORD_WIDTH-1:0] req_palm_z,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic signed [31:0]            rsp_quat_x,
   output logic signed [31:0]            rsp_quat_y,
   output logic signed [31:0]            rsp_quat_z,
   output logic signed [31:0]            rsp_quat_w
);
   import sbq_pkg::*;

   localparam int CW = COORD_WIDTH;

   logic en;
   logic rsp_valid_ff;
   assign en        = !rsp_valid_ff || rsp_ready;
   assign req_ready = en;

   // S0: bone difference
   logic                  s0_valid_ff;
   logic [2:0][CW:0]      s0_d_ff;
   logic [2:0][CW-1:0]    s0_p_ff;

   always_ff @(posedge clock) begin
      if (reset) s0_valid_ff <= 1'b0;
      else if (en) s0_valid_ff <= req_valid;
      if (en) begin
         s0_d_ff[0] <= $signed({req_child_x[CW-1], req_child_x})
                     - $signed({req_parent_x[CW-1], req_parent_x});
         s0_d_ff[1] <= $signed({req_child_y[CW-1], req_child_y})
                     - $signed({req_parent_y[CW-1], req_parent_y});
         s0_d_ff[2] <= $signed({req_child_z[CW-1], req_child_z})
                     - $signed({req_parent_z[CW-1], req_parent_z});
         s0_p_ff    <= {req_palm_z, req_palm_y, req_palm_x};
      end
   end

   logic               ny_valid, ny_ok;
   axis_type           ny_comp;
   logic [3*CW-1:0]    ny_side;

   sbq_norm #(.N(3), .VW(CW+1), .FRAC(30), .USE_EPS(1), .SIDE_W(3*CW)) u_norm_y (
      .clock(clock), .reset(reset), .en(en), .in_valid(s0_valid_ff),
      .vec_i(s0_d_ff), .uexp_i(-8'sd16), .side_i(s0_p_ff),
      .out_valid(ny_valid), .out_ok(ny_ok), .out_comp(ny_comp), .side_o(ny_side)
   );

   // B1: hint products and palm prescale
   logic               b1_valid_ff, b1_hsel_ff;
   axis_type           b1_y_ff, b1_y_in;
   logic [2:0][63:0]   b1_ph_ff, b1_ph_in;
   logic [2:0][30:0]   b1_ps_ff, b1_ps_in;
   logic signed [7:0]  b1_kp_ff, b1_kp_in;
   logic               b1_hsel_in;

   always_comb begin
      logic [31:0]        ay1, hy;
      logic [2:0][CW-1:0] pv;
      logic [2:0][CW-1:0] pmag;
      logic [CW-1:0]      mx;
      logic [63:0]        ext;
      logic [7:0]         nk;
      logic [29:0]        pm;
      b1_y_in    = ny_ok ? ny_comp : {32'd0, UNIT_ONE, 32'd0};
      ay1        = b1_y_in[1][31] ? (~b1_y_in[1] + 1'b1) : b1_y_in[1];
      b1_hsel_in = ay1 < HINT_LIMIT;
      hy         = b1_hsel_in ? b1_y_in[1] : b1_y_in[0];
      for (int i = 0; i < 3; i++) begin
         b1_ph_in[i] = 64'($signed(b1_y_in[i]) * $signed(hy));
      end
      pv = ny_side;
      mx = '0;
      for (int i = 0; i < 3; i++) begin
         pmag[i] = pv[i][CW-1] ? (~pv[i] + 1'b1) : pv[i];
         if (pmag[i] > mx) mx = pmag[i];
      end
      b1_kp_in = 8'sd29 - $signed({2'b00, msb_pos(64'(mx))});
      nk = 8'(-b1_kp_in);
      for (int i = 0; i < 3; i++) begin
         ext = 64'(pmag[i]);
         pm  = b1_kp_in[7] ? 30'(ext >> nk) : 30'(ext << b1_kp_in);
         b1_ps_in[i] = pv[i][CW-1] ? (~{1'b0, pm} + 1'b1) : {1'b0, pm};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) b1_valid_ff <= 1'b0;
      else if (en) b1_valid_ff <= ny_valid;
      if (en) begin
         b1_y_ff    <= b1_y_in;
         b1_hsel_ff <= b1_hsel_in;
         b1_ph_ff   <= b1_ph_in;
         b1_ps_ff   <= b1_ps_in;
         b1_kp_ff   <= b1_kp_in;
      end
   end

   // B2: fallback residual, palm dot terms
   logic               b2_valid_ff;
   axis_type           b2_y_ff;
   logic [2:0][33:0]   b2_rfb_ff, b2_rfb_in;
   logic [2:0][62:0]   b2_dp_ff;
   logic [2:0][30:0]   b2_ps_ff;
   logic signed [7:0]  b2_kp_ff;

   always_comb begin
      logic signed [33:0] hv;
      for (int i = 0; i < 3; i++) begin
         hv = ((i == 1 && b1_hsel_ff) || (i == 0 && !b1_hsel_ff)) ? 34'sh4000_0000 : 34'sd0;
         b2_rfb_in[i] = hv - 34'(rnd30($signed(66'($signed(b1_ph_ff[i])))));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) b2_valid_ff <= 1'b0;
      else if (en) b2_valid_ff <= b1_valid_ff;
      if (en) begin
         b2_y_ff   <= b1_y_ff;
         b2_rfb_ff <= b2_rfb_in;
         for (int i = 0; i < 3; i++) begin
            b2_dp_ff[i] <= 63'($signed(b1_ps_ff[i]) * $signed(b1_y_ff[i]));
         end
         b2_ps_ff  <= b1_ps_ff;
         b2_kp_ff  <= b1_kp_ff;
      end
   end

   // B3: rounded dot product
   logic               b3_valid_ff;
   axis_type           b3_y_ff;
   logic [2:0][33:0]   b3_rfb_ff;
   logic [2:0][30:0]   b3_ps_ff;
   logic signed [7:0]  b3_kp_ff;
   logic signed [32:0] b3_dot_ff, b3_dot_in;

   always_comb begin
      logic signed [65:0] acc;
      acc = '0;
      for (int i = 0; i < 3; i++) acc = acc + 66'($signed(b2_dp_ff[i]));
      b3_dot_in = 33'(rnd30(acc));
   end

   always_ff @(posedge clock) begin
      if (reset) b3_valid_ff <= 1'b0;
      else if (en) b3_valid_ff <= b2_valid_ff;
      if (en) begin
         b3_y_ff   <= b2_y_ff;
         b3_rfb_ff <= b2_rfb_ff;
         b3_ps_ff  <= b2_ps_ff;
         b3_kp_ff  <= b2_kp_ff;
         b3_dot_ff <= b3_dot_in;
      end
   end

   // B4: y * dot
   logic               b4_valid_ff;
   axis_type           b4_y_ff;
   logic [2:0][33:0]   b4_rfb_ff;
   logic [2:0][30:0]   b4_ps_ff;
   logic signed [7:0]  b4_kp_ff;
   logic [2:0][64:0]   b4_pd_ff;

   always_ff @(posedge clock) begin
      if (reset) b4_valid_ff <= 1'b0;
      else if (en) b4_valid_ff <= b3_valid_ff;
      if (en) begin
         b4_y_ff   <= b3_y_ff;
         b4_rfb_ff <= b3_rfb_ff;
         b4_ps_ff  <= b3_ps_ff;
         b4_kp_ff  <= b3_kp_ff;
         for (int i = 0; i < 3; i++) begin
            b4_pd_ff[i] <= 65'($signed(b3_y_ff[i]) * b3_dot_ff);
         end
      end
   end

   // B5: palm residual
   logic               b5_valid_ff;
   axis_type           b5_y_ff;
   logic [2:0][33:0]   b5_rfb_ff, b5_rp_ff, b5_rp_in;
   logic signed [7:0]  b5_uexp_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         b5_rp_in[i] = 34'($signed(b4_ps_ff[i]))
                     - 34'(rnd30($signed(66'($signed(b4_pd_ff[i])))));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) b5_valid_ff <= 1'b0;
      else if (en) b5_valid_ff <= b4_valid_ff;
      if (en) begin
         b5_y_ff    <= b4_y_ff;
         b5_rfb_ff  <= b4_rfb_ff;
         b5_rp_ff   <= b5_rp_in;
         b5_uexp_ff <= -8'sd16 - b4_kp_ff;
      end
   end

   logic        nf_valid, nf_ok, np_ok;
   axis_type    nf_comp, np_comp;
   logic [95:0] nf_side;

   sbq_norm #(.N(3), .VW(34), .FRAC(30), .USE_EPS(1), .SIDE_W(96)) u_norm_fb (
      .clock(clock), .reset(reset), .en(en), .in_valid(b5_valid_ff),
      .vec_i(b5_rfb_ff), .uexp_i(-8'sd30), .side_i(b5_y_ff),
      .out_valid(nf_valid), .out_ok(nf_ok), .out_comp(nf_comp), .side_o(nf_side)
   );

   sbq_norm #(.N(3), .VW(34), .FRAC(30), .USE_EPS(1), .SIDE_W(1)) u_norm_palm (
      .clock(clock), .reset(reset), .en(en), .in_valid(b5_valid_ff),
      .vec_i(b5_rp_ff), .uexp_i(b5_uexp_ff), .side_i(1'b0),
      .out_valid(), .out_ok(np_ok), .out_comp(np_comp), .side_o()
   );

   // C1: x axis select
   logic       c1_valid_ff;
   axis_type   c1_x_ff, c1_y_ff;

   always_ff @(posedge clock) begin
      if (reset) c1_valid_ff <= 1'b0;
      else if (en) c1_valid_ff <= nf_valid;
      if (en) begin
         c1_x_ff <= np_ok ? np_comp : (nf_ok ? nf_comp : {32'd0, 32'd0, UNIT_ONE});
         c1_y_ff <= nf_side;
      end
   end

   // C2: cross products
   logic              c2_valid_ff;
   axis_type          c2_x_ff, c2_y_ff;
   logic [2:0][63:0]  c2_a_ff, c2_b_ff;

   always_ff @(posedge clock) begin
      if (reset) c2_valid_ff <= 1'b0;
      else if (en) c2_valid_ff <= c1_valid_ff;
      if (en) begin
         c2_x_ff    <= c1_x_ff;
         c2_y_ff    <= c1_y_ff;
         c2_a_ff[0] <= 64'($signed(c1_x_ff[1]) * $signed(c1_y_ff[2]));
         c2_b_ff[0] <= 64'($signed(c1_x_ff[2]) * $signed(c1_y_ff[1]));
         c2_a_ff[1] <= 64'($signed(c1_x_ff[2]) * $signed(c1_y_ff[0]));
         c2_b_ff[1] <= 64'($signed(c1_x_ff[0]) * $signed(c1_y_ff[2]));
         c2_a_ff[2] <= 64'($signed(c1_x_ff[0]) * $signed(c1_y_ff[1]));
         c2_b_ff[2] <= 64'($signed(c1_x_ff[1]) * $signed(c1_y_ff[0]));
      end
   end

   // C3: rounded cross
   logic              c3_valid_ff;
   axis_type          c3_x_ff, c3_y_ff;
   logic [2:0][33:0]  c3_c_ff, c3_c_in;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         c3_c_in[i] = 34'(rnd30(66'($signed(c2_a_ff[i])) - 66'($signed(c2_b_ff[i]))));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) c3_valid_ff <= 1'b0;
      else if (en) c3_valid_ff <= c2_valid_ff;
      if (en) begin
         c3_x_ff <= c2_x_ff;
         c3_y_ff <= c2_y_ff;
         c3_c_ff <= c3_c_in;
      end
   end

   logic         nz_valid, nz_ok;
   axis_type     nz_comp;
   logic [191:0] nz_side;

   sbq_norm #(.N(3), .VW(34), .FRAC(30), .USE_EPS(1), .SIDE_W(192)) u_norm_z (
      .clock(clock), .reset(reset), .en(en), .in_valid(c3_valid_ff),
      .vec_i(c3_c_ff), .uexp_i(-8'sd30), .side_i({c3_x_ff, c3_y_ff}),
      .out_valid(nz_valid), .out_ok(nz_ok), .out_comp(nz_comp), .side_o(nz_side)
   );

   // D1: trace method
   logic              d1_valid_ff;
   logic [3:0][34:0]  d1_q_ff, d1_q_in;

   always_comb begin
      axis_type x, y, z;
      logic signed [34:0] x0, x1, x2, y0, y1, y2, z0, z1, z2, one, tr;
      x = nz_side[191:96];
      y = nz_side[95:0];
      z = nz_ok ? nz_comp : {UNIT_ONE, 32'd0, 32'd0};
      x0 = 35'($signed(x[0])); x1 = 35'($signed(x[1])); x2 = 35'($signed(x[2]));
      y0 = 35'($signed(y[0])); y1 = 35'($signed(y[1])); y2 = 35'($signed(y[2]));
      z0 = 35'($signed(z[0])); z1 = 35'($signed(z[1])); z2 = 35'($signed(z[2]));
      one = 35'sh4000_0000;
      tr  = x0 + y1 + z2;
      if (tr > 0) begin
         d1_q_in[0] = y2 - z1;  d1_q_in[1] = z0 - x2;
         d1_q_in[2] = x1 - y0;  d1_q_in[3] = tr + one;
      end else if (x0 > y1 && x0 > z2) begin
         d1_q_in[0] = one + x0 - y1 - z2;  d1_q_in[1] = y0 + x1;
         d1_q_in[2] = z0 + x2;             d1_q_in[3] = y2 - z1;
      end else if (y1 > z2) begin
         d1_q_in[0] = y0 + x1;  d1_q_in[1] = one + y1 - x0 - z2;
         d1_q_in[2] = z1 + y2;  d1_q_in[3] = z0 - x2;
      end else begin
         d1_q_in[0] = z0 + x2;  d1_q_in[1] = z1 + y2;
         d1_q_in[2] = one + z2 - x0 - y1;  d1_q_in[3] = x1 - y0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) d1_valid_ff <= 1'b0;
      else if (en) d1_valid_ff <= nz_valid;
      if (en) d1_q_ff <= d1_q_in;
   end

   logic             nq_valid, nq_ok;
   logic [3:0][31:0] nq_comp;

   sbq_norm #(.N(4), .VW(35), .FRAC(QUAT_FRAC_BITS), .USE_EPS(0), .SIDE_W(1)) u_norm_q (
      .clock(clock), .reset(reset), .en(en), .in_valid(d1_valid_ff),
      .vec_i(d1_q_ff), .uexp_i(8'sd0), .side_i(1'b0),
      .out_valid(nq_valid), .out_ok(nq_ok), .out_comp(nq_comp), .side_o()
   );

   // output register
   logic [3:0][31:0] rsp_q_ff;

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else if (en) rsp_valid_ff <= nq_valid;
      if (en) begin
         rsp_q_ff <= nq_ok ? nq_comp
                           : {32'(64'd1 << QUAT_FRAC_BITS), 32'd0, 32'd0, 32'd0};
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_quat_x = $signed(rsp_q_ff[0]);
   assign rsp_quat_y = $signed(rsp_q_ff[1]);
   assign rsp_quat_z = $signed(rsp_q_ff[2]);
   assign rsp_quat_w = $signed(rsp_q_ff[3]);

endmodule
